// ===== sv/amgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgc_pkg
// Shared constants, class codes and controller/datapath interface types for
// the adjacency matrix graph classifier.
// ----------------------------------------------------------------------------
package amgc_pkg;

    // Default largest matrix side
    localparam int DEFAULT_MAX_SIDE = 64;

    // Fixed field widths
    localparam int ENTRY_W = 8;
    localparam int CLASS_W = 3;
    localparam int SIDE_W  = 7;

    // Graph class codes
    localparam logic [CLASS_W-1:0] CLS_SIMPLE_DIRECTED   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_MULTI_DIRECTED    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_PSEUDOGRAPH       = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_SIMPLE_UNDIRECTED = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_MULTI_UNDIRECTED  = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch entry, issue transposed read
        logic commit;    // compare, write entry, advance counters
    } amgc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_cell; // current cell closes the matrix
    } amgc_status_t;

endpackage

// ===== sv/amgc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/amgc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgc_ctrl
// Controller: sequences each item through read and commit, and owns the
// input ready and the output valid of the result register.
// ----------------------------------------------------------------------------
module amgc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  amgc_pkg::amgc_status_t status,
    output amgc_pkg::amgc_cmd_t    cmd
);
    import amgc_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic commit;

    // Take an item only when no item is in flight
    assign s_tready = (state_reg == ST_IDLE);

    // Hold the closing cell while a previous result still waits
    assign commit = (state_reg == ST_CHECK) &&
                    (!status.last_cell || !out_valid_reg || m_tready);

    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = commit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on the closing cell, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit && status.last_cell)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/amgc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgc_dp
// Datapath: side register, row/column counters, running flags, entry store
// and the class result register.
// ----------------------------------------------------------------------------
module amgc_dp #(
    parameter int MAX_SIDE = amgc_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [amgc_pkg::SIDE_W-1:0]    cfg_side,
    input  logic [amgc_pkg::ENTRY_W-1:0]   entry_value,
    input  amgc_pkg::amgc_cmd_t            cmd,
    output amgc_pkg::amgc_status_t         status,
    output logic [amgc_pkg::CLASS_W-1:0]   graph_class
);
    import amgc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [IDX_W-1:0]   side_m1_reg;
    logic [IDX_W-1:0]   side_m1_next;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;
    logic               sym_reg;
    logic               zdiag_reg;
    logic               simple_reg;
    logic               sym_next;
    logic               zdiag_next;
    logic               simple_next;
    logic [ENTRY_W-1:0] value_reg;
    logic [ENTRY_W-1:0] trans_value;
    logic [CLASS_W-1:0] class_reg;
    logic [CLASS_W-1:0] class_next;
    logic               last_col;
    logic               last_cell;

    // Clamp the written side to 1..MAX_SIDE, keep side minus one
    always_comb
    begin
        if (cfg_side == '0)
        begin
            side_m1_next = '0;
        end
        else if (32'(cfg_side) > MAX_SIDE)
        begin
            side_m1_next = IDX_W'(MAX_SIDE - 1);
        end
        else
        begin
            side_m1_next = IDX_W'(cfg_side - SIDE_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_m1_reg <= '0;
        end
        else if (cfg_we)
        begin
            side_m1_reg <= side_m1_next;
        end
    end

    assign last_col  = (col_reg == side_m1_reg);
    assign last_cell = last_col && (row_reg == side_m1_reg);
    assign status.last_cell = last_cell;

    // Entry store: read the transposed cell, write the current cell
    amgc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr ({row_reg, col_reg}),
        .wdata (value_reg),
        .re    (cmd.capture),
        .raddr ({col_reg, row_reg}),
        .rdata (trans_value)
    );

    // Latch the incoming entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= entry_value;
        end
    end

    // Updated flags for the current cell
    always_comb
    begin
        sym_next    = sym_reg && !((col_reg < row_reg) && (trans_value != value_reg));
        zdiag_next  = zdiag_reg && !((row_reg == col_reg) && (value_reg != '0));
        simple_next = simple_reg && (value_reg <= ENTRY_W'(1));
    end

    // Class from the final flags
    always_comb
    begin
        if (!sym_next)
        begin
            class_next = simple_next ? CLS_SIMPLE_DIRECTED : CLS_MULTI_DIRECTED;
        end
        else if (!zdiag_next)
        begin
            class_next = CLS_PSEUDOGRAPH;
        end
        else
        begin
            class_next = simple_next ? CLS_SIMPLE_UNDIRECTED : CLS_MULTI_UNDIRECTED;
        end
    end

    // Advance counters and flags; restart on a side write or a closed matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            sym_reg    <= 1'b1;
            zdiag_reg  <= 1'b1;
            simple_reg <= 1'b1;
        end
        else if (cfg_we || (cmd.commit && last_cell))
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            sym_reg    <= 1'b1;
            zdiag_reg  <= 1'b1;
            simple_reg <= 1'b1;
        end
        else if (cmd.commit)
        begin
            sym_reg    <= sym_next;
            zdiag_reg  <= zdiag_next;
            simple_reg <= simple_next;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + IDX_W'(1);
            end
            else
            begin
                col_reg <= col_reg + IDX_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit && last_cell)
        begin
            class_reg <= class_next;
        end
    end

    assign graph_class = class_reg;

endmodule

// ===== sv/adjacency_matrix_graph_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_classifier
// Classifies a square adjacency matrix streamed in row-major order.
// ----------------------------------------------------------------------------
// Each entry has its transposed cell read from the entry store RAM through
// the read register of its single read port, then is compared, written
// back and folded into the flags; a new entry waits until the last is
// committed. After the last cell of a matrix one class item is placed
// in an output register; the next matrix may start while it waits, and only
// the next closing cell stalls until it has been taken. Writing matrix_side
// (clamped to 1..MAX_SIDE, zero taken as one) restarts the current matrix.
// Classes: 0 simple directed, 1 multi directed, 2 pseudograph, 3 simple
// undirected, 4 multi undirected. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_classifier #(
    parameter int MAX_SIDE = amgc_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: matrix_side
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [amgc_pkg::SIDE_W-1:0] cfg_data,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] entry_value
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [2:0] graph_class, [7:3] zero
);
    import amgc_pkg::*;

    amgc_cmd_t          cmd;
    amgc_status_t       status;
    logic [CLASS_W-1:0] graph_class;

    assign cfg_ready = 1'b1;

    amgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    amgc_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_side    (cfg_data),
        .entry_value (s_tdata[ENTRY_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .graph_class (graph_class)
    );

    // Pad the class to a whole byte
    assign m_tdata = {{(8 - CLASS_W){1'b0}}, graph_class};

endmodule

// ===== sim/adjacency_matrix_graph_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_classifier_test
// Self-checking testbench for the adjacency matrix graph classifier. Matrices
// are streamed in row-major order at several side settings. A local
// predictor of the class keeps its own entry store and flags. Each class
// the block emits is checked against the oldest predicted class.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_classifier_test;
    import amgc_pkg::*;

    localparam int SIDE_MAX      = DEFAULT_MAX_SIDE;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ENTRIES = 220;
    localparam int RANDOM_CLASSES = 30;

    // Shapes of generated matrices
    typedef enum int {
        MAT_SIMPLE_UNDIR,
        MAT_MULTI_UNDIR,
        MAT_LOOPED,
        MAT_SIMPLE_DIR,
        MAT_MULTI_DIR,
        MAT_NOISE
    } matrix_kind_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SIDE_W-1:0]  cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [7:0] entry_value
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;          // [2:0] graph_class, [7:3] zero

    // Predictor state
    logic [ENTRY_W-1:0] cell_mem [0:SIDE_MAX*SIDE_MAX-1];
    logic [SIDE_W-1:0]  side_reg;
    int unsigned        row_idx;
    int unsigned        col_idx;
    bit                 sym_ok;
    bit                 diag_zero;
    bit                 simple_ok;
    logic [CLASS_W-1:0] pending_classes [$];
    int                 classes_predicted = 0;
    int                 entries_sent      = 0;
    int                 error_count       = 0;

    // Source and sink pacing
    bit                 no_idle   = 1'b0;
    int                 hold_left = 0;

    adjacency_matrix_graph_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned active_side(input logic [SIDE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > SIDE_MAX)
            return SIDE_MAX;
        return 32'(s);
    endfunction

    task automatic model_restart();
        row_idx   = 0;
        col_idx   = 0;
        sym_ok    = 1'b1;
        diag_zero = 1'b1;
        simple_ok = 1'b1;
    endtask

    // Fold one entry into the flags; push a class when the matrix closes
    task automatic model_entry(input logic [ENTRY_W-1:0] v);
        int unsigned        side_now;
        logic [CLASS_W-1:0] cls;
        side_now = active_side(side_reg);
        if (col_idx < row_idx && cell_mem[col_idx*SIDE_MAX + row_idx] != v)
            sym_ok = 1'b0;
        if (row_idx == col_idx && v != 0)
            diag_zero = 1'b0;
        if (v > 1)
            simple_ok = 1'b0;
        cell_mem[row_idx*SIDE_MAX + col_idx] = v;
        if (col_idx + 1 < side_now)
        begin
            col_idx++;
        end
        else if (row_idx + 1 < side_now)
        begin
            col_idx = 0;
            row_idx++;
        end
        else
        begin
            if (!sym_ok)
                cls = simple_ok ? CLS_SIMPLE_DIRECTED : CLS_MULTI_DIRECTED;
            else if (!diag_zero)
                cls = CLS_PSEUDOGRAPH;
            else
                cls = simple_ok ? CLS_SIMPLE_UNDIRECTED : CLS_MULTI_UNDIRECTED;
            pending_classes.push_back(cls);
            classes_predicted++;
            model_restart();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one entry; valid stays high after acceptance so that a following
    // entry can go back to back
    task automatic send_entry(input logic [ENTRY_W-1:0] v);
        if (!no_idle && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 29);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        model_entry(v);
        entries_sent++;
    endtask

    // Drop valid and wait until every predicted class has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write matrix_side while the block is idle
    task automatic write_side(input logic [SIDE_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        side_reg = v;
        model_restart();
    endtask

    // Build one matrix of the given shape and stream it row by row
    task automatic send_matrix(input int n, input matrix_kind_t kind);
        logic [ENTRY_W-1:0] grid [0:SIDE_MAX-1][0:SIDE_MAX-1];
        bit                 multi;
        multi = (kind == MAT_MULTI_UNDIR || kind == MAT_MULTI_DIR || kind == MAT_LOOPED);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if (kind == MAT_NOISE)
                    grid[r][c] = ENTRY_W'($urandom_range(0, 255));
                else if (multi && $urandom_range(0, 1))
                    grid[r][c] = ENTRY_W'($urandom_range(0, 255));
                else
                    grid[r][c] = ENTRY_W'($urandom_range(0, 1));
            end
        end
        case (kind)
            MAT_SIMPLE_UNDIR, MAT_MULTI_UNDIR, MAT_LOOPED:
            begin
                // mirror the upper triangle
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < r; c++)
                        grid[r][c] = grid[c][r];
                if (kind == MAT_LOOPED)
                begin
                    grid[n-1][n-1] = ENTRY_W'($urandom_range(1, 255));
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                        grid[k][k] = '0;
                    if (kind == MAT_MULTI_UNDIR && n >= 2)
                    begin
                        grid[0][n-1] = ENTRY_W'($urandom_range(2, 255));
                        grid[n-1][0] = grid[0][n-1];
                    end
                end
            end
            MAT_SIMPLE_DIR, MAT_MULTI_DIR:
            begin
                // break symmetry on one pair
                if (n >= 2)
                    grid[n-1][0] = grid[0][n-1] ^ 8'd1;
            end
            default:
            begin
            end
        endcase
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_entry(grid[r][c]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Side 1 out of reset: every entry is a diagonal cell and closes a matrix
    task automatic test_reset_side();
        send_entry(8'd0);
        send_entry(8'd255);
    endtask

    // Side 0 behaves as side 1
    task automatic test_side_zero();
        write_side(7'd0);
        send_entry(8'd0);
    endtask

    // Abandon a matrix halfway; the next side write restarts it
    task automatic test_restart_mid_matrix();
        write_side(7'd3);
        send_entry(8'd1);
        send_entry(8'd7);
        send_entry(8'd0);
        send_entry(8'd3);
    endtask

    // One 2x2 matrix per class
    task automatic test_every_class();
        logic [ENTRY_W-1:0] cases [0:4][0:3];
        cases[0] = '{8'd0, 8'd1,   8'd0,   8'd0};  // simple directed
        cases[1] = '{8'd0, 8'd2,   8'd1,   8'd0};  // multi directed
        cases[2] = '{8'd1, 8'd1,   8'd1,   8'd0};  // pseudograph
        cases[3] = '{8'd0, 8'd1,   8'd1,   8'd0};  // simple undirected
        cases[4] = '{8'd0, 8'd200, 8'd200, 8'd0};  // multi undirected
        write_side(7'd2);
        for (int m = 0; m < 5; m++)
            for (int k = 0; k < 4; k++)
                send_entry(cases[m][k]);
    endtask

    // Side 64 partly filled, then side 127 saturated to 64 partly filled;
    // each side write drops the open matrix
    task automatic test_largest_side();
        write_side(7'd64);
        for (int k = 0; k < 70; k++)
            send_entry(ENTRY_W'($urandom_range(0, 255)));
        write_side(7'd127);
        for (int k = 0; k < 70; k++)
            send_entry(ENTRY_W'($urandom_range(0, 255)));
    endtask

    // No idling on either side for a stretch
    task automatic test_back_to_back();
        write_side(7'd4);
        no_idle = 1'b1;
        for (int m = 0; m < 8; m++)
            send_matrix(4, matrix_kind_t'($urandom_range(0, 5)));
        no_idle = 1'b0;
    endtask

    // Hold the result side off while one-cell matrices keep coming, so the
    // output register fills and input stalls; then pause until all drained
    task automatic test_output_backpressure();
        write_side(7'd1);
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < 16; k++)
            send_entry(ENTRY_W'($urandom_range(0, 255)));
        wait_drained();
    endtask

    // Random phases of mostly well-formed matrices, some noise and some
    // matrices cut short by the next side write
    task automatic test_random_matrices();
        int          first_entry;
        int          first_class;
        int unsigned n;
        int          count;
        first_entry = entries_sent;
        first_class = classes_predicted;
        while (entries_sent - first_entry < RANDOM_ENTRIES ||
               classes_predicted - first_class < RANDOM_CLASSES)
        begin
            if ($urandom_range(0, 3) == 0)
                write_side(7'd1);
            else
                write_side(SIDE_W'($urandom_range(0, 7)));
            n = active_side(side_reg);
            count = $urandom_range(1, 5);
            for (int m = 0; m < count; m++)
                send_matrix(n, matrix_kind_t'($urandom_range(0, 5)));
            if (n > 1 && $urandom_range(0, 99) < 15)
            begin
                count = $urandom_range(1, n*n - 1);
                for (int k = 0; k < count; k++)
                    send_entry(ENTRY_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: pacing, checking, watchdog
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (no_idle)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Compare each class with the oldest prediction
    initial
    begin : class_checker
        logic [CLASS_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_classes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: class %0d with none expected", $time, m_tdata[2:0]);
                end
                else
                begin
                    want = pending_classes.pop_front();
                    if (m_tdata[2:0] !== want)
                    begin
                        error_count++;
                        $display("%0t: graph_class expected %0d actual %0d",
                                 $time, want, m_tdata[2:0]);
                    end
                    if (m_tdata[7:3] !== 5'd0)
                    begin
                        error_count++;
                        $display("%0t: tdata padding expected 0 actual %0h",
                                 $time, m_tdata[7:3]);
                    end
                end
            end
        end
    end

    // End the run when nothing moves on any channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        side_reg = 7'd1;
        model_restart();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_side();
        test_side_zero();
        test_restart_mid_matrix();
        test_every_class();
        test_largest_side();
        test_back_to_back();
        test_output_backpressure();
        test_random_matrices();

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/amgc_pkg.sv
sv/amgc_ram.sv
sv/amgc_ctrl.sv
sv/amgc_dp.sv
sv/adjacency_matrix_graph_classifier.sv
sim/adjacency_matrix_graph_classifier_test.sv
